@@ src/rsc_pkg.sv @@
// rsc_pkg: shared types, codes and helper functions of the radix string converter.
// Holds the controller/datapath command and status structs. No dependencies.
package rsc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_IBASE = 2'd0;
    localparam logic [1:0] REG_OBASE = 2'd1;

    // radix select codes
    localparam logic [1:0] SEL_BIN = 2'd0;
    localparam logic [1:0] SEL_DEC = 2'd1;
    localparam logic [1:0] SEL_OCT = 2'd2;
    localparam logic [1:0] SEL_HEX = 2'd3;

    // divider operand sources
    localparam logic [1:0] DIV_SRC_WGT = 2'd0;
    localparam logic [1:0] DIV_SRC_INT = 2'd1;
    localparam logic [1:0] DIV_SRC_ACC = 2'd2;

    // output character sources
    localparam logic EMIT_RAM = 1'b0;
    localparam logic EMIT_DOT = 1'b1;

    localparam logic [7:0] CHAR_DOT = 8'h2E;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } digit_t;

    typedef struct packed {
        logic       load;
        logic       parse;
        logic       div_load;
        logic [1:0] div_src;
        logic       div_step;
        logic       div_restart;
        logic       wgt_store;
        logic       dec_init;
        logic       dec_step;
        logic       round;
        logic       k_clear;
        logic       store;
        logic       rd;
        logic       emit;
        logic       emit_src;
        logic       frac_step;
        logic       clear;
        logic       sec;
    } rsc_cmd_t;

    typedef struct packed {
        logic need_wdiv;
        logic last;
        logic dec_mode;
        logic div_done;
        logic q_zero;
        logic k_zero;
        logic k_dec_last;
        logic dcnt_last;
        logic frac_zero;
        logic frac_step_last;
        logic out_free;
    } rsc_stat_t;

    function automatic logic [4:0] radix_of(input logic [1:0] sel);
        logic [4:0] r;
        case (sel)
            SEL_BIN: r = 5'd2;
            SEL_DEC: r = 5'd10;
            SEL_OCT: r = 5'd8;
            default: r = 5'd16;
        endcase
        return r;
    endfunction

    function automatic digit_t digit_of(input logic [7:0] c, input logic [1:0] sel);
        digit_t     r;
        logic [7:0] d;
        logic       ok;
        ok = 1'b1;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end else begin
            d  = 8'd0;
            ok = 1'b0;
        end
        r.valid = ok && (d[4:0] < radix_of(sel));
        r.val   = d[3:0];
        return r;
    endfunction

    function automatic logic [7:0] ascii_of(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'd0, d};
        end else begin
            r = 8'h37 + {4'd0, d};
        end
        return r;
    endfunction

endpackage

@@ src/radix_string_converter.sv @@
// radix_string_converter: top level, joins the sequencer and the datapath.
// Depends on rsc_pkg, rsc_ctrl, rsc_datapath (which holds rsc_ram).
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data | in
//  in       | in_valid in_ready in_char in_last      | in
//  out      | out_valid out_ready out_char out_last saturated | out
//
// A character is loaded, then parsed; a fraction digit adds an N-chunk weight division,
// N = ceil(max(FRAC_BITS, INT_BITS+1, bits of 10^DEC_FRAC_DIGITS) / 16), one 16-bit chunk
// a cycle (N = 3 at the defaults). On the last character each integer digit (and decimal
// fraction digit) takes a chunked division and a RAM read-out; decimal output first scales
// and rounds; other fraction digits take one multiply step each. Output stalls hold the
// sequencer; input is taken only when no result is in progress. Reset is asynchronous.
module radix_string_converter #(
    parameter int INT_BITS        = 32,
    parameter int FRAC_BITS       = 48,
    parameter int FRAC_DIGITS     = 10,
    parameter int DEC_FRAC_DIGITS = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       out_last,
    output logic       saturated
);
    import rsc_pkg::*;

    rsc_cmd_t  cmd;
    rsc_stat_t st;

    assign cfg_ready = 1'b1;

    rsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    rsc_datapath #(
        .INT_BITS        (INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .FRAC_DIGITS     (FRAC_DIGITS),
        .DEC_FRAC_DIGITS (DEC_FRAC_DIGITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_char   (in_char),
        .in_last   (in_last),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_char  (out_char),
        .out_last  (out_last),
        .saturated (saturated),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

@@ src/rsc_ram.sv @@
// rsc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/rsc_datapath.sv @@
// rsc_datapath: parse registers, chunked constant divider, digit buffer and output register.
// Depends on rsc_pkg and rsc_ram; driven by rsc_ctrl through rsc_cmd_t.
module rsc_datapath #(
    parameter int INT_BITS        = 32,
    parameter int FRAC_BITS       = 48,
    parameter int FRAC_DIGITS     = 10,
    parameter int DEC_FRAC_DIGITS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        out_char,
    output logic              out_last,
    output logic              saturated,
    input  rsc_pkg::rsc_cmd_t cmd,
    output rsc_pkg::rsc_stat_t st
);
    import rsc_pkg::*;

    localparam int IW        = INT_BITS + 1;
    localparam int LIM       = 10 ** DEC_FRAC_DIGITS;
    localparam int ACC_W     = $clog2(LIM + 1);
    localparam int DW0       = (FRAC_BITS > IW) ? FRAC_BITS : IW;
    localparam int DW        = (DW0 > ACC_W) ? DW0 : ACC_W;
    localparam int NCH       = (DW + 15) / 16;
    localparam int DP        = 16 * NCH;
    localparam int CW        = $clog2(NCH + 1);
    localparam int BUF_DEPTH = IW;
    localparam int AW        = $clog2(BUF_DEPTH);
    localparam int KW        = $clog2(BUF_DEPTH + 1);
    localparam int FD_MAX    = (FRAC_DIGITS > DEC_FRAC_DIGITS) ? FRAC_DIGITS : DEC_FRAC_DIGITS;
    localparam int FW        = $clog2(FD_MAX + 1);

    localparam logic [FRAC_BITS:0]   ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] W_BIN   = FRAC_BITS'(ONE / 2);
    localparam logic [FRAC_BITS-1:0] W_DEC   = FRAC_BITS'(ONE / 10);
    localparam logic [FRAC_BITS-1:0] W_OCT   = FRAC_BITS'(ONE / 8);
    localparam logic [FRAC_BITS-1:0] W_HEX   = FRAC_BITS'(ONE / 16);
    localparam logic [IW+3:0]        INT_MAX = {5'd0, {INT_BITS{1'b1}}};
    // floor(x * RCP10 / 2^35) is x / 10 for any 32-bit x
    localparam logic [31:0]          RCP10   = 32'hCCCC_CCCD;

    logic [1:0]           ibase_reg, ibase_next, obase_reg, obase_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;
    logic [IW-1:0]        int_reg, int_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next, wgt_reg, wgt_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 stop_reg, stop_next, ovf_reg, ovf_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [DP-1:0]        dvd_reg, dvd_next;
    logic [3:0]           rem_reg, rem_next;
    logic [4:0]           dv_reg, dv_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [FW-1:0]        fd_reg, fd_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;
    logic                 sat_reg, sat_next;
    logic                 out_valid_reg, out_valid_next;

    digit_t               dg;
    logic                 is_dot;
    logic [IW+3:0]        int_ext, int_mul, int_sum;
    logic [FRAC_BITS-1:0] dw_prod;
    logic [FRAC_BITS+3:0] fx, f10, fb_mul;
    logic [ACC_W-1:0]     acc10, acc_r;
    logic [19:0]          dv_in;
    logic [51:0]          rcp_prod;
    logic [15:0]          q10;
    logic [19:0]          r10;
    logic [15:0]          q_chunk;
    logic [3:0]           r_chunk;
    logic [KW-1:0]        k_dec;
    logic [3:0]           ram_rdata;
    logic                 out_free;
    logic                 dec_mode;
    logic                 fstep_last;

    assign dg       = digit_of(char_reg, ibase_reg);
    assign is_dot   = (char_reg == CHAR_DOT);
    assign dec_mode = (obase_reg == SEL_DEC);
    assign out_free = !out_valid_reg || out_ready;
    assign fx       = {4'd0, frac_reg};
    assign f10      = (fx << 3) + (fx << 1);
    assign acc10    = (acc_reg << 3) + (acc_reg << 1) + ACC_W'(f10[FRAC_BITS+3:FRAC_BITS]);
    assign acc_r    = acc_reg + ACC_W'(frac_reg[FRAC_BITS-1]);
    assign k_dec    = k_reg - KW'(1);
    assign int_ext  = (IW+4)'(int_reg[INT_BITS-1:0]);
    assign int_sum  = int_mul + (IW+4)'(dg.val);

    // divider works on 16 bits a cycle: running remainder above the next chunk
    assign dv_in    = {rem_reg, dvd_reg[DP-1:DP-16]};
    assign rcp_prod = {32'd0, dv_in} * {20'd0, RCP10};
    assign q10      = rcp_prod[50:35];
    assign r10      = dv_in - (({4'd0, q10}) << 3) - (({4'd0, q10}) << 1);

    always_comb
    begin
        case (dv_reg)
            5'd2:
            begin
                q_chunk = dv_in[16:1];
                r_chunk = {3'd0, dv_in[0]};
            end
            5'd8:
            begin
                q_chunk = dv_in[18:3];
                r_chunk = {1'b0, dv_in[2:0]};
            end
            5'd16:
            begin
                q_chunk = dv_in[19:4];
                r_chunk = dv_in[3:0];
            end
            default:
            begin
                q_chunk = q10;
                r_chunk = r10[3:0];
            end
        endcase
    end

    always_comb
    begin
        case (ibase_reg)
            SEL_BIN: int_mul = int_ext << 1;
            SEL_OCT: int_mul = int_ext << 3;
            SEL_HEX: int_mul = int_ext << 4;
            default: int_mul = (int_ext << 3) + (int_ext << 1);
        endcase
        case (obase_reg)
            SEL_BIN: fb_mul = fx << 1;
            SEL_OCT: fb_mul = fx << 3;
            default: fb_mul = fx << 4;
        endcase
    end

    // digit times weight, four shifted partial products
    always_comb
    begin
        dw_prod = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (dg.val[i])
            begin
                dw_prod = dw_prod + (wgt_reg << i);
            end
        end
    end

    assign fstep_last = (fd_reg == FW'(FRAC_DIGITS - 1)) || (fb_mul[FRAC_BITS-1:0] == '0);

    always_comb
    begin
        ibase_next     = ibase_reg;
        obase_next     = obase_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        int_next       = int_reg;
        frac_next      = frac_reg;
        wgt_next       = wgt_reg;
        phase_next     = phase_reg;
        stop_next      = stop_reg;
        ovf_next       = ovf_reg;
        acc_next       = acc_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        fd_next        = fd_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IBASE: ibase_next = cfg_data;
                REG_OBASE: obase_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.load)
        begin
            char_next = in_char;
            last_next = in_last;
        end

        if (cmd.parse && phase_reg != 2'd2)
        begin
            if (is_dot)
            begin
                if (phase_reg == 2'd0)
                begin
                    phase_next = 2'd1;
                    case (ibase_reg)
                        SEL_BIN: wgt_next = W_BIN;
                        SEL_OCT: wgt_next = W_OCT;
                        SEL_HEX: wgt_next = W_HEX;
                        default: wgt_next = W_DEC;
                    endcase
                end
                else
                begin
                    phase_next = 2'd2;
                end
            end
            else if (phase_reg == 2'd0)
            begin
                if (!stop_reg)
                begin
                    if (!dg.valid)
                    begin
                        stop_next = 1'b1;
                    end
                    else if (int_sum > INT_MAX)
                    begin
                        int_next = IW'(INT_MAX);
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        int_next = IW'(int_sum);
                    end
                end
            end
            else if (dg.valid)
            begin
                frac_next = frac_reg + dw_prod;
            end
        end

        // divider: load, restart on quotient, one 16-bit quotient chunk per step
        if (cmd.div_load)
        begin
            case (cmd.div_src)
                DIV_SRC_WGT:
                begin
                    dvd_next = DP'(wgt_reg);
                    dv_next  = radix_of(ibase_reg);
                end
                DIV_SRC_INT:
                begin
                    dvd_next = DP'(int_reg);
                    dv_next  = radix_of(obase_reg);
                end
                default:
                begin
                    dvd_next = DP'(acc_reg);
                    dv_next  = 5'd10;
                end
            endcase
            rem_next = 4'd0;
            cnt_next = '0;
        end
        else if (cmd.div_restart)
        begin
            rem_next = 4'd0;
            cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = r_chunk;
            dvd_next = (dvd_reg << 16) | DP'(q_chunk);
            cnt_next = cnt_reg + CW'(1);
        end

        if (cmd.wgt_store)
        begin
            wgt_next = dvd_reg[FRAC_BITS-1:0];
        end

        if (cmd.dec_init)
        begin
            acc_next = '0;
            fd_next  = '0;
        end
        if (cmd.dec_step)
        begin
            acc_next  = acc10;
            frac_next = f10[FRAC_BITS-1:0];
            fd_next   = fd_reg + FW'(1);
        end
        if (cmd.round)
        begin
            // rounding carry out of the fraction goes into the integer part
            if (acc_r == ACC_W'(LIM))
            begin
                acc_next = '0;
                int_next = int_reg + IW'(1);
            end
            else
            begin
                acc_next = acc_r;
            end
        end

        if (cmd.k_clear)
        begin
            k_next  = '0;
            fd_next = '0;
        end
        if (cmd.store)
        begin
            k_next = k_reg + KW'(1);
        end
        if (cmd.rd)
        begin
            k_next = k_dec;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            sat_next       = ovf_reg;
            if (cmd.emit_src == EMIT_DOT)
            begin
                out_char_next = CHAR_DOT;
                out_last_next = 1'b0;
            end
            else
            begin
                out_char_next = ascii_of(ram_rdata);
                out_last_next = (k_reg == '0)
                                && (cmd.sec || (!dec_mode && frac_reg == '0));
            end
        end
        if (cmd.frac_step)
        begin
            out_valid_next = 1'b1;
            sat_next       = ovf_reg;
            out_char_next  = ascii_of(fb_mul[FRAC_BITS+3:FRAC_BITS]);
            out_last_next  = fstep_last;
            frac_next      = fb_mul[FRAC_BITS-1:0];
            fd_next        = fd_reg + FW'(1);
        end

        if (cmd.clear)
        begin
            int_next   = '0;
            frac_next  = '0;
            phase_next = 2'd0;
            stop_next  = 1'b0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ibase_reg     <= SEL_DEC;
            obase_reg     <= SEL_BIN;
            int_reg       <= '0;
            frac_reg      <= '0;
            phase_reg     <= 2'd0;
            stop_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            rem_reg       <= 4'd0;
            dv_reg        <= 5'd2;
            cnt_reg       <= CW'(NCH);
            k_reg         <= '0;
            fd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ibase_reg     <= ibase_next;
            obase_reg     <= obase_next;
            int_reg       <= int_next;
            frac_reg      <= frac_next;
            phase_reg     <= phase_next;
            stop_reg      <= stop_next;
            ovf_reg       <= ovf_next;
            rem_reg       <= rem_next;
            dv_reg        <= dv_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            fd_reg        <= fd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        last_reg     <= last_next;
        wgt_reg      <= wgt_next;
        acc_reg      <= acc_next;
        dvd_reg      <= dvd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        sat_reg      <= sat_next;
    end

    rsc_ram #(
        .WIDTH (4),
        .DEPTH (BUF_DEPTH)
    ) u_digits (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (k_reg[AW-1:0]),
        .wdata (rem_reg),
        .re    (cmd.rd),
        .raddr (k_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign st.need_wdiv      = (phase_reg == 2'd1) && !is_dot && dg.valid;
    assign st.last           = last_reg;
    assign st.dec_mode       = dec_mode;
    assign st.div_done       = (cnt_reg == CW'(NCH));
    assign st.q_zero         = (dvd_reg == '0);
    assign st.k_zero         = (k_reg == '0);
    assign st.k_dec_last     = (k_reg == KW'(DEC_FRAC_DIGITS - 1));
    assign st.dcnt_last      = (fd_reg == FW'(DEC_FRAC_DIGITS - 1));
    assign st.frac_zero      = (frac_reg == '0);
    assign st.frac_step_last = fstep_last;
    assign st.out_free       = out_free;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign saturated = sat_reg;

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < dv_reg)
        else $error("divider remainder not below divisor");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= KW'(BUF_DEPTH))
        else $error("digit count beyond buffer depth");

    a_wgt_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wgt_store |-> (cnt_reg == CW'(NCH)))
        else $error("weight taken before division finished");
`endif

endmodule

@@ src/rsc_ctrl.sv @@
// rsc_ctrl: sequencer for parsing and digit generation of the radix string converter.
// Depends on rsc_pkg; commands rsc_datapath through rsc_cmd_t.
module rsc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rsc_pkg::rsc_stat_t st,
    output rsc_pkg::rsc_cmd_t  cmd
);
    import rsc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PARSE = 4'd1;
    localparam logic [3:0] S_WDIV  = 4'd2;
    localparam logic [3:0] S_EMIT0 = 4'd3;
    localparam logic [3:0] S_DLOOP = 4'd4;
    localparam logic [3:0] S_ROUND = 4'd5;
    localparam logic [3:0] S_ILOAD = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_STORE = 4'd8;
    localparam logic [3:0] S_RD    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_DOT   = 4'd11;
    localparam logic [3:0] S_ALOAD = 4'd12;
    localparam logic [3:0] S_FRAC  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       sec_reg, sec_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sec_next   = sec_reg;
        cmd        = '0;
        cmd.sec    = sec_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                cmd.parse = 1'b1;
                if (st.need_wdiv)
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_src  = DIV_SRC_WGT;
                    state_next   = S_WDIV;
                end
                else
                begin
                    state_next = st.last ? S_EMIT0 : S_IDLE;
                end
            end
            S_WDIV:
            begin
                if (st.div_done)
                begin
                    cmd.wgt_store = 1'b1;
                    state_next    = st.last ? S_EMIT0 : S_IDLE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EMIT0:
            begin
                if (st.dec_mode)
                begin
                    cmd.dec_init = 1'b1;
                    state_next   = S_DLOOP;
                end
                else
                begin
                    state_next = S_ILOAD;
                end
            end
            S_DLOOP:
            begin
                cmd.dec_step = 1'b1;
                if (st.dcnt_last)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_ILOAD;
            end
            S_ILOAD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_SRC_INT;
                cmd.k_clear  = 1'b1;
                sec_next     = 1'b0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                // integer stops at a zero quotient, fraction after DEC_FRAC_DIGITS digits
                if (sec_reg ? st.k_dec_last : st.q_zero)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    cmd.div_restart = 1'b1;
                    state_next      = S_DIV;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EMIT_RAM;
                    if (!st.k_zero)
                    begin
                        state_next = S_RD;
                    end
                    else if (sec_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (st.dec_mode || !st.frac_zero)
                    begin
                        state_next = S_DOT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DOT:
            begin
                if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = EMIT_DOT;
                    cmd.k_clear  = 1'b1;
                    state_next   = st.dec_mode ? S_ALOAD : S_FRAC;
                end
            end
            S_ALOAD:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = DIV_SRC_ACC;
                cmd.k_clear  = 1'b1;
                sec_next     = 1'b1;
                state_next   = S_DIV;
            end
            S_FRAC:
            begin
                if (st.out_free)
                begin
                    cmd.frac_step = 1'b1;
                    if (st.frac_step_last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
        end
    end

`ifndef SYNTH
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.frac_step) |-> st.out_free)
        else $error("output overwritten while occupied");

    a_accept_parses: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_PARSE))
        else $error("accepted character not parsed");

    a_store_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> ($past(state_reg) == S_DIV && st.div_done))
        else $error("digit stored before division finished");
`endif

endmodule
